>>> hdl/sbv_pkg.sv
// Shared types, constants and codes for the sphere band vertex generator.
package sbv_pkg;

	localparam int DEF_MAX_HSLICES = 63;
	localparam int DEF_MAX_VSLICES = 256;
	localparam int DEF_ANGLE_BITS  = 16;

	localparam int QDEPTH = 2;

	localparam logic [8:0]  RST_NUM_VSLICES = 9'd16;
	localparam logic [5:0]  RST_NUM_HSLICES = 6'd16;
	localparam logic [7:0]  RST_START_RING  = 8'd0;
	localparam logic [15:0] RST_U_TILING    = 16'd256;
	localparam logic [15:0] RST_V_TILING    = 16'd256;

	// quarter-wave sine polynomial coefficients, Q30
	localparam logic [31:0] K1 = 32'd1686629713;
	localparam logic [31:0] K3 = 32'd693598669;
	localparam logic [31:0] K5 = 32'd85569306;
	localparam logic [31:0] K7 = 32'd5026995;
	localparam logic [31:0] K9 = 32'd172272;

	typedef enum logic [2:0] {
		REG_NUM_VSLICES = 3'd0,
		REG_NUM_HSLICES = 3'd1,
		REG_START_RING  = 3'd2,
		REG_U_TILING    = 3'd3,
		REG_V_TILING    = 3'd4
	} cfg_reg_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_DIV,
		BK_DIVW,
		BK_SIN,
		BK_MUL
	} back_state_t;

	typedef enum logic [2:0] {
		OP_LAT_LO,
		OP_LAT_HI,
		OP_V_LO,
		OP_V_HI,
		OP_LON_STEP,
		OP_U_STEP
	} div_op_t;

	typedef enum logic [2:0] {
		SJ_COS_LO,
		SJ_SIN_LO,
		SJ_COS_HI,
		SJ_SIN_HI,
		SJ_COS_LON,
		SJ_SIN_LON
	} sin_job_t;

	typedef struct packed {
		logic [8:0]  num_vslices;
		logic [5:0]  num_hslices;
		logic [7:0]  start_ring;
		logic [15:0] u_tiling;
		logic [15:0] v_tiling;
	} cfg_t;

	// one queued ring, slice counts already clamped
	typedef struct packed {
		logic [7:0]        ring;
		logic [8:0]        nv;
		logic [5:0]        nh;
		logic signed [9:0] d;
	} band_t;

endpackage

>>> hdl/sphere_band_vertex_generator_unit.sv
// Sphere band vertex generator: one ring index in, nh+1 vertex-pair results out.
// Per ring: take it from the queue, six divisions (DW = max(ANGLE_BITS+9, 25) bits),
// four latitude sines, then per column (nh+1 columns) two longitude sines and products on
// the shared multiplier; each strobe is registered with its column's outputs. Throughput
// is set by that multiplier and divider; a two-ring queue takes new items while a ring
// is being worked. Results are never stalled. Reset empties queue, sets config defaults.
module sphere_band_vertex_generator_unit import sbv_pkg::*; #(
	parameter int MAX_HSLICES = DEF_MAX_HSLICES,
	parameter int MAX_VSLICES = DEF_MAX_VSLICES,
	parameter int ANGLE_BITS  = DEF_ANGLE_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [7:0]         ring_index,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	output logic               strobe,
	output logic [5:0]         column,
	output logic signed [15:0] lower_x,
	output logic signed [15:0] lower_y,
	output logic signed [15:0] lower_z,
	output logic signed [15:0] upper_x,
	output logic signed [15:0] upper_y,
	output logic signed [15:0] upper_z,
	output logic [15:0]        tex_u,
	output logic [15:0]        lower_v,
	output logic [15:0]        upper_v,
	output logic               last_column
);

	logic  pop;
	logic  nonempty;
	band_t head;
	cfg_t  cfg;

	sbv_front #(
		.MAX_HSLICES (MAX_HSLICES),
		.MAX_VSLICES (MAX_VSLICES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.ring_index (ring_index),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pop        (pop),
		.nonempty   (nonempty),
		.head       (head),
		.cfg        (cfg)
	);

	sbv_back #(.ANGLE_BITS(ANGLE_BITS)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.nonempty    (nonempty),
		.head        (head),
		.cfg         (cfg),
		.pop         (pop),
		.strobe      (strobe),
		.column      (column),
		.lower_x     (lower_x),
		.lower_y     (lower_y),
		.lower_z     (lower_z),
		.upper_x     (upper_x),
		.upper_y     (upper_y),
		.upper_z     (upper_z),
		.tex_u       (tex_u),
		.lower_v     (lower_v),
		.upper_v     (upper_v),
		.last_column (last_column)
	);

endmodule

>>> hdl/sbv_div.sv
// Restoring divider, one quotient bit per cycle.
module sbv_div import sbv_pkg::*; #(
	parameter int DW = 25,
	parameter int VW = 10
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient,
	output logic [VW-1:0] remainder
);

	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0] dq_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] div_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;
	logic [VW:0]   trial;
	logic [VW:0]   nrem;
	logic          ge;

	assign trial = {rem_q, dq_q[DW-1]};
	assign ge    = trial >= {1'b0, div_q};
	assign nrem  = ge ? trial - {1'b0, div_q} : trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(DW - 1);
			end else if (run_q) begin
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (run_q) begin
			rem_q <= nrem[VW-1:0];
			dq_q  <= {dq_q[DW-2:0], ge};
		end
	end

	assign done      = done_q;
	assign quotient  = dq_q;
	assign remainder = rem_q;

endmodule

>>> hdl/sbv_front.sv
// Front end: configuration registers, ring classification and a two-entry queue.
module sbv_front import sbv_pkg::*; #(
	parameter int MAX_HSLICES = DEF_MAX_HSLICES,
	parameter int MAX_VSLICES = DEF_MAX_VSLICES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  ring_index,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        pop,
	output logic        nonempty,
	output band_t       head,
	output cfg_t        cfg
);

	cfg_t       cfg_q;
	band_t      ent_q [QDEPTH];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;
	band_t      cls;

	assign cfg_ready = 1'b1;
	assign busy      = cnt_q == 2'(QDEPTH);
	assign push      = start && !busy;
	assign nonempty  = cnt_q != 2'd0;
	assign head      = ent_q[rd_q];
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_vslices <= RST_NUM_VSLICES;
			cfg_q.num_hslices <= RST_NUM_HSLICES;
			cfg_q.start_ring  <= RST_START_RING;
			cfg_q.u_tiling    <= RST_U_TILING;
			cfg_q.v_tiling    <= RST_V_TILING;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_NUM_VSLICES: cfg_q.num_vslices <= cfg_data[8:0];
				REG_NUM_HSLICES: cfg_q.num_hslices <= cfg_data[5:0];
				REG_START_RING:  cfg_q.start_ring  <= cfg_data[7:0];
				REG_U_TILING:    cfg_q.u_tiling    <= cfg_data;
				REG_V_TILING:    cfg_q.v_tiling    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		cls.ring = ring_index;
		if (cfg_q.num_vslices == 9'd0)
			cls.nv = 9'd1;
		else if (cfg_q.num_vslices > 9'(MAX_VSLICES))
			cls.nv = 9'(MAX_VSLICES);
		else
			cls.nv = cfg_q.num_vslices;
		if (cfg_q.num_hslices == 6'd0)
			cls.nh = 6'd1;
		else if (cfg_q.num_hslices > 6'(MAX_HSLICES))
			cls.nh = 6'(MAX_HSLICES);
		else
			cls.nh = cfg_q.num_hslices;
		cls.d = $signed({2'b00, ring_index}) - $signed({2'b00, cfg_q.start_ring});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (pop)
				rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_q] <= cls;
	end

endmodule

>>> hdl/sbv_back.sv
// Back end: per-ring divisions, shared sine/product multiplier and column sequencer.
module sbv_back import sbv_pkg::*; #(
	parameter int ANGLE_BITS = DEF_ANGLE_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               nonempty,
	input  band_t              head,
	input  cfg_t               cfg,
	output logic               pop,
	output logic               strobe,
	output logic [5:0]         column,
	output logic signed [15:0] lower_x,
	output logic signed [15:0] lower_y,
	output logic signed [15:0] lower_z,
	output logic signed [15:0] upper_x,
	output logic signed [15:0] upper_y,
	output logic signed [15:0] upper_z,
	output logic [15:0]        tex_u,
	output logic [15:0]        lower_v,
	output logic [15:0]        upper_v,
	output logic               last_column
);

	localparam int AB = ANGLE_BITS;
	localparam int DW = (AB + 9 > 25) ? AB + 9 : 25;
	localparam int VW = 10;
	localparam logic [AB-1:0] QUARTER = AB'(1) << (AB - 2);
	localparam logic [AB-1:0] THREEQ  = AB'(3) << (AB - 2);

	back_state_t state_q, state_d;
	div_op_t     op_q;
	sin_job_t    sj_q;
	logic [2:0]  stp_q;
	band_t       band_q;

	logic          div_start;
	logic          div_done;
	logic [DW-1:0] div_a;
	logic [VW-1:0] div_b;
	logic [DW-1:0] quo;
	logic [VW-1:0] rem;

	logic [AB-1:0] la_q, ua_q, lon_q, q0_q;
	logic [5:0]    lonr_q, r0_q, tur_q, r1_q, col_q;
	logic [21:0]   tu_q;
	logic [15:0]   q1_q, lv_q, uv_q;
	logic signed [15:0] cl_q, sl_q, cu_q, su_q, co_q, so_q;

	logic [63:0] p_q;
	logic [31:0] z2_q;
	logic [31:0] ma, mb;
	logic [63:0] tsub;
	logic [31:0] kk;

	logic [AB-1:0]   ang;
	logic [1:0]      quad;
	logic [AB+13:0]  zw;
	logic [16:0]     z;
	logic [63:0]     sr;
	logic [31:0]     s;
	logic [14:0]     m;
	logic signed [15:0] sval;

	logic signed [9:0] d1;
	logic [8:0]  dl, d1l;
	logic [24:0] vp0, vp1;
	logic [15:0] vsat;

	logic [1:0]  ik, sk;
	logic signed [15:0] pa_i, pb_i, pa_s, pb_s;
	logic [15:0] abs_a, abs_b;
	logic [15:0] mres;
	logic signed [15:0] mval;

	logic [6:0]  lsum, tsum;
	logic        lge, tge;
	logic        last;

	// next state and control
	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (nonempty) begin
					pop     = 1'b1;
					state_d = BK_DIV;
				end
			end
			BK_DIV: begin
				div_start = 1'b1;
				state_d   = BK_DIVW;
			end
			BK_DIVW: begin
				if (div_done)
					state_d = (op_q == OP_U_STEP) ? BK_SIN : BK_DIV;
			end
			BK_SIN: begin
				if (stp_q == 3'd6 && sj_q == SJ_SIN_LON)
					state_d = BK_MUL;
			end
			BK_MUL: begin
				if (stp_q == 3'd4)
					state_d = last ? BK_IDLE : BK_SIN;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			op_q    <= OP_LAT_LO;
			sj_q    <= SJ_COS_LO;
			stp_q   <= 3'd0;
			strobe  <= 1'b0;
		end else begin
			state_q <= state_d;
			strobe  <= state_q == BK_MUL && stp_q == 3'd4;
			unique case (state_q)
				BK_IDLE: begin
					op_q  <= OP_LAT_LO;
					sj_q  <= SJ_COS_LO;
					stp_q <= 3'd0;
				end
				BK_DIVW: begin
					if (div_done && op_q != OP_U_STEP)
						op_q <= div_op_t'(op_q + 3'd1);
				end
				BK_SIN: begin
					if (stp_q == 3'd6) begin
						stp_q <= 3'd0;
						if (sj_q != SJ_SIN_LON)
							sj_q <= sin_job_t'(sj_q + 3'd1);
					end else begin
						stp_q <= stp_q + 3'd1;
					end
				end
				BK_MUL: begin
					if (stp_q == 3'd4) begin
						stp_q <= 3'd0;
						sj_q  <= SJ_COS_LON;
					end else begin
						stp_q <= stp_q + 3'd1;
					end
				end
				default: ;
			endcase
		end
	end

	// division operands
	assign d1  = band_q.d + 10'sd1;
	assign dl  = (band_q.d > 10'sd0) ? band_q.d[8:0] : 9'd0;
	assign d1l = (d1 > 10'sd0) ? d1[8:0] : 9'd0;
	assign vp0 = 25'(dl) * 25'(cfg.v_tiling);
	assign vp1 = 25'(d1l) * 25'(cfg.v_tiling);

	always_comb begin
		div_a = '0;
		div_b = '0;
		unique case (op_q)
			OP_LAT_LO: begin
				div_a = (DW'(band_q.ring) << AB) + DW'(band_q.nv);
				div_b = {band_q.nv, 1'b0};
			end
			OP_LAT_HI: begin
				div_a = (DW'({1'b0, band_q.ring} + 9'd1) << AB) + DW'(band_q.nv);
				div_b = {band_q.nv, 1'b0};
			end
			OP_V_LO: begin
				div_a = DW'(vp0) + DW'(band_q.nv >> 1);
				div_b = {1'b0, band_q.nv};
			end
			OP_V_HI: begin
				div_a = DW'(vp1) + DW'(band_q.nv >> 1);
				div_b = {1'b0, band_q.nv};
			end
			OP_LON_STEP: begin
				div_a = DW'(1) << AB;
				div_b = VW'(band_q.nh);
			end
			OP_U_STEP: begin
				div_a = DW'(cfg.u_tiling);
				div_b = VW'(band_q.nh);
			end
			default: ;
		endcase
	end

	sbv_div #(.DW(DW), .VW(VW)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_a),
		.divisor   (div_b),
		.done      (div_done),
		.quotient  (quo),
		.remainder (rem)
	);

	assign vsat = (|quo[DW-1:16]) ? 16'hFFFF : quo[15:0];

	// sine argument
	always_comb begin
		unique case (sj_q)
			SJ_COS_LO:  ang = la_q + QUARTER;
			SJ_SIN_LO:  ang = la_q;
			SJ_COS_HI:  ang = ua_q + QUARTER;
			SJ_SIN_HI:  ang = ua_q;
			SJ_COS_LON: ang = lon_q + QUARTER;
			SJ_SIN_LON: ang = lon_q;
			default:    ang = lon_q;
		endcase
	end

	assign quad = ang[AB-1:AB-2];
	assign zw   = {ang[AB-3:0], 16'd0} >> (AB - 2);
	assign z    = quad[0] ? 17'h10000 - {1'b0, zw[15:0]} : {1'b0, zw[15:0]};
	assign sr   = p_q + 64'h8000_0000;
	assign s    = sr[63:32];
	assign m    = (s > 32'd16384) ? 15'd16384 : s[14:0];
	assign sval = quad[1] ? -$signed({1'b0, m}) : $signed({1'b0, m});

	// product pairs
	assign ik   = stp_q[1:0];
	assign sk   = 2'(stp_q - 3'd1);
	assign pa_i = ik[1] ? cu_q : cl_q;
	assign pb_i = ik[0] ? so_q : co_q;
	assign pa_s = sk[1] ? cu_q : cl_q;
	assign pb_s = sk[0] ? so_q : co_q;
	assign abs_a = pa_i[15] ? 16'(-pa_i) : pa_i;
	assign abs_b = pb_i[15] ? 16'(-pb_i) : pb_i;
	assign mres  = 16'((p_q[29:0] + 30'd8192) >> 14);
	assign mval  = (pa_s[15] ^ pb_s[15]) ? -$signed(mres) : $signed(mres);

	always_comb begin
		unique case (stp_q)
			3'd2:    kk = K7;
			3'd3:    kk = K5;
			3'd4:    kk = K3;
			default: kk = K1;
		endcase
		tsub = 64'(kk) - (p_q >> 30);
		ma = '0;
		mb = '0;
		if (state_q == BK_SIN) begin
			unique case (stp_q)
				3'd0: begin
					ma = 32'(z);
					mb = 32'(z);
				end
				3'd1: begin
					ma = p_q[33:2];
					mb = K9;
				end
				3'd2, 3'd3, 3'd4: begin
					ma = z2_q;
					mb = tsub[31:0];
				end
				3'd5: begin
					ma = 32'(z);
					mb = tsub[31:0];
				end
				default: ;
			endcase
		end else if (state_q == BK_MUL) begin
			ma = 32'(abs_a);
			mb = 32'(abs_b);
		end
	end

	assign lsum = {1'b0, lonr_q} + {1'b0, r0_q};
	assign tsum = {1'b0, tur_q} + {1'b0, r1_q};
	assign lge  = lsum >= {1'b0, band_q.nh};
	assign tge  = tsum >= {1'b0, band_q.nh};
	assign last = col_q == band_q.nh;

	// datapath
	always_ff @(posedge clk) begin
		p_q <= {32'd0, ma} * {32'd0, mb};
		if (pop)
			band_q <= head;
		if (state_q == BK_DIVW && div_done) begin
			unique case (op_q)
				OP_LAT_LO: la_q <= quo[AB-1:0] + THREEQ;
				OP_LAT_HI: ua_q <= quo[AB-1:0] + THREEQ;
				OP_V_LO:   lv_q <= (band_q.d > 10'sd0) ? vsat : 16'd0;
				OP_V_HI:   uv_q <= (d1 > 10'sd0) ? vsat : 16'd0;
				OP_LON_STEP: begin
					q0_q <= quo[AB-1:0];
					r0_q <= rem[5:0];
				end
				OP_U_STEP: begin
					q1_q   <= quo[15:0];
					r1_q   <= rem[5:0];
					lon_q  <= '0;
					lonr_q <= band_q.nh >> 1;
					tu_q   <= '0;
					tur_q  <= band_q.nh >> 1;
					col_q  <= '0;
				end
				default: ;
			endcase
		end
		if (state_q == BK_SIN) begin
			if (stp_q == 3'd1)
				z2_q <= p_q[33:2];
			if (stp_q == 3'd6) begin
				unique case (sj_q)
					SJ_COS_LO:  cl_q <= sval;
					SJ_SIN_LO:  sl_q <= sval;
					SJ_COS_HI:  cu_q <= sval;
					SJ_SIN_HI:  su_q <= sval;
					SJ_COS_LON: co_q <= sval;
					SJ_SIN_LON: so_q <= sval;
					default: ;
				endcase
			end
		end
		if (state_q == BK_MUL) begin
			unique case (stp_q)
				3'd1: lower_x <= mval;
				3'd2: lower_y <= mval;
				3'd3: upper_x <= mval;
				3'd4: begin
					upper_y     <= mval;
					lower_z     <= sl_q;
					upper_z     <= su_q;
					column      <= col_q;
					tex_u       <= (|tu_q[21:16]) ? 16'hFFFF : tu_q[15:0];
					lower_v     <= lv_q;
					upper_v     <= uv_q;
					last_column <= last;
					col_q       <= col_q + 6'd1;
					lonr_q      <= lge ? 6'(lsum - {1'b0, band_q.nh}) : lsum[5:0];
					lon_q       <= lon_q + q0_q + AB'(lge);
					tur_q       <= tge ? 6'(tsum - {1'b0, band_q.nh}) : tsum[5:0];
					tu_q        <= tu_q + 22'(q1_q) + 22'(tge);
				end
				default: ;
			endcase
		end
	end

endmodule
